@@ sv/bpi_pkg.sv @@
// Package for the balance position indicator.
// Holds widths, register indexes, reset values, the controller state type
// and the command, status and configuration structs. No dependencies.
package bpi_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int LED_COUNT   = 16;
  localparam int POS_W       = $clog2(LED_COUNT);
  localparam int GAIN_W      = 6;
  localparam int OFFSET_W    = 4;
  localparam int QUO_W       = GAIN_W;
  localparam int NUM_W       = GAIN_W + SAMPLE_BITS;
  localparam int DEN_W       = SAMPLE_BITS + 1;
  localparam int STEP_W      = $clog2(QUO_W);
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(20);
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(2);

  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NET,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [OFFSET_W-1:0] offset;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic net;
    logic mul;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

@@ sv/bpi_regs.sv @@
// Configuration register file behind the APB-style port.
// Holds gain and offset; depends on bpi_pkg.
module bpi_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [bpi_pkg::ADDR_W-1:0] paddr,
  input  logic [bpi_pkg::DATA_W-1:0] pwdata,
  output logic [bpi_pkg::DATA_W-1:0] prdata,
  output logic                   pready,
  output bpi_pkg::cfg_t          cfg
);
  import bpi_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain   <= GAIN_RESET;
      cfg.offset <= OFFSET_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_GAIN:   cfg.gain   <= pwdata[GAIN_W-1:0];
        REG_OFFSET: cfg.offset <= pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_GAIN:   prdata = DATA_W'(cfg.gain);
      REG_OFFSET: prdata = DATA_W'(cfg.offset);
      default:    prdata = '0;
    endcase
  end

endmodule

@@ sv/bpi_ctrl.sv @@
// Controller state machine: sequences capture, net load, multiply,
// divider steps and result hand-off. Depends on bpi_pkg.
module bpi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bpi_pkg::sts_t sts,
  output bpi_pkg::cmd_t cmd
);
  import bpi_pkg::*;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              last_step;

  assign last_step = (step == STEP_W'(QUO_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: if (in_valid) state_next = S_NET;
      S_NET:  state_next = S_MUL;
      S_MUL: begin
        state_next = S_DIV;
        step_next  = '0;
      end
      S_DIV: begin
        step_next = step + STEP_W'(1);
        if (last_step) state_next = S_FIN;
      end
      S_FIN:  if (!sts.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_NET:  cmd.net      = 1'b1;
      S_MUL:  cmd.mul      = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_FIN:  cmd.finish   = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

@@ sv/bpi_datapath.sv @@
// Datapath: running minima, net loads, gain multiply, restoring divider,
// clamp and output register. Depends on bpi_pkg.
module bpi_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  bpi_pkg::cmd_t                cmd,
  input  bpi_pkg::cfg_t                cfg,
  output bpi_pkg::sts_t                sts,
  input  logic [bpi_pkg::SAMPLE_BITS-1:0] reading_a,
  input  logic [bpi_pkg::SAMPLE_BITS-1:0] reading_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bpi_pkg::POS_W-1:0]    position,
  output logic [bpi_pkg::LED_COUNT-1:0] led_mask,
  output logic [bpi_pkg::SAMPLE_BITS-1:0] net_a,
  output logic [bpi_pkg::SAMPLE_BITS-1:0] net_b
);
  import bpi_pkg::*;

  logic [SAMPLE_BITS-1:0] ra, rb, floor_a, floor_b, min_a, min_b;
  logic [SAMPLE_BITS-1:0] na, nb;
  logic [NUM_W-1:0]       rem, ds;
  logic [DEN_W-1:0]       den;
  logic [QUO_W-1:0]       quo, diff;
  logic [POS_W-1:0]       pos_c;

  assign sts.out_busy = out_valid && !out_ready;

  assign min_a = (ra < floor_a) ? ra : floor_a;
  assign min_b = (rb < floor_b) ? rb : floor_b;
  assign den   = DEN_W'(na) + DEN_W'(nb) + DEN_W'(1);

  always_comb begin
    diff  = quo - QUO_W'(cfg.offset);
    pos_c = '0;
    if (quo >= QUO_W'(cfg.offset)) begin
      if (diff > QUO_W'(LED_COUNT - 1)) pos_c = POS_W'(LED_COUNT - 1);
      else pos_c = diff[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_a <= '1;
      floor_b <= '1;
    end else if (cmd.net) begin
      floor_a <= min_a;
      floor_b <= min_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ra <= reading_a;
      rb <= reading_b;
    end
    if (cmd.net) begin
      na <= ra - min_a;
      nb <= rb - min_b;
    end
    if (cmd.mul) begin
      rem <= NUM_W'(cfg.gain) * NUM_W'(na);
      ds  <= {den, (QUO_W-1)'(0)};
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem >= ds) begin
        rem <= rem - ds;
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
      ds <= ds >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      position <= pos_c;
      led_mask <= LED_COUNT'(1) << pos_c;
      net_a    <= na;
      net_b    <= nb;
    end
  end

endmodule

@@ sv/balance_position_indicator.sv @@
// Top level of the balance position indicator: register file, controller
// and datapath. Depends on bpi_pkg, bpi_regs, bpi_ctrl, bpi_datapath.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------
//   input    | in_valid/in_ready  | reading_a, reading_b
//   output   | out_valid/out_ready| position, led_mask, net_a, net_b
//   config   | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// An item goes from transfer to result through capture, net load,
// multiply, then six steps of the restoring divider (one quotient bit each).
// The next item is taken once the result is in the output register, so a
// stalled output holds back at most one further item at its final step.
// Synchronous reset restores gain 20, offset 2 and both minima to all ones.
module balance_position_indicator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bpi_pkg::SAMPLE_BITS-1:0] reading_a,
  input  logic [bpi_pkg::SAMPLE_BITS-1:0] reading_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bpi_pkg::POS_W-1:0]    position,
  output logic [bpi_pkg::LED_COUNT-1:0] led_mask,
  output logic [bpi_pkg::SAMPLE_BITS-1:0] net_a,
  output logic [bpi_pkg::SAMPLE_BITS-1:0] net_b,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpi_pkg::ADDR_W-1:0]   paddr,
  input  logic [bpi_pkg::DATA_W-1:0]   pwdata,
  output logic [bpi_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import bpi_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  bpi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpi_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .sts       (sts),
    .reading_a (reading_a),
    .reading_b (reading_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .position  (position),
    .led_mask  (led_mask),
    .net_a     (net_a),
    .net_b     (net_b)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one in flight");

  a_mask_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (led_mask == (LED_COUNT'(1) << position)))
    else $error("led_mask disagrees with position");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result raised without finish command");

endmodule
